### sv/bcs_pkg.sv
`default_nettype none
package bcs_pkg;

  localparam logic [2:0] CFG_SRC_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_SRC_HEIGHT  = 3'd1;
  localparam logic [2:0] CFG_OUT_WIDTH   = 3'd2;
  localparam logic [2:0] CFG_OUT_HEIGHT  = 3'd3;
  localparam logic [2:0] CFG_IMAGE_VALID = 3'd4;
  localparam logic [2:0] CFG_FILL_COLOR  = 3'd5;

  localparam logic OP_STORE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic [7:0] ALPHA = 8'hff;

  localparam logic [8:0]  RST_SRC_WIDTH  = 9'd256;
  localparam logic [8:0]  RST_SRC_HEIGHT = 9'd256;
  localparam logic [12:0] RST_OUT_WIDTH  = 13'd1920;
  localparam logic [12:0] RST_OUT_HEIGHT = 13'd1080;
  localparam logic [23:0] RST_FILL_COLOR = 24'd856343;

  localparam logic [2:0] SETTLE_CYCLES = 3'd6;

  typedef struct packed {
    logic        vld;
    logic        op;
    logic        in_rect;
    logic [11:0] x;
    logic [11:0] y;
    logic [23:0] pix;
  } side_t;

endpackage
`default_nettype wire

### sv/bilinear_contain_scaler_top.sv
`default_nettype none
// Bilinear contain scaler. Store words write source pixels into four parity banks of an
// on-chip image memory; compute words return one letterboxed, bilinearly interpolated
// ARGB pixel each. The pipeline takes one word per clock unless the input stalls; its depth
// is set by the two bit-per-stage source coordinate dividers, whose quotients are NW bits
// wide, where NW = FRAC_BITS plus the coordinate product width (32 with the default
// parameters). A spare output register catches the result that is in flight when the
// output stalls, so the input stall is driven from registers only. After reset and after
// every register write the input stalls while the scale and placement registers settle.
module bilinear_contain_scaler_top
  import bcs_pkg::*;
#(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int OUT_COORD_BITS = 12,
  parameter int FRAC_BITS      = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        operation_i,
  input  wire logic [11:0] coord_x_i,
  input  wire logic [11:0] coord_y_i,
  input  wire logic [23:0] pixel_in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      pixel_out_o,
  output logic             inside_image_o
);

  localparam int WB = $clog2(MAX_SRC_WIDTH + 1);
  localparam int HB = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int SB = (WB > HB) ? WB : HB;
  localparam int OB = OUT_COORD_BITS + 1;
  localparam int XB = (OB > 13) ? OB : 13;
  localparam int PW = XB + SB + 2;
  localparam int F  = FRAC_BITS;
  localparam int NW = PW + F;
  localparam int DW = OB + 1;
  localparam int FW = SB + F;
  localparam int MW = OB + SB;
  localparam int HW = (MAX_SRC_WIDTH + 1) / 2;
  localparam int HH = (MAX_SRC_HEIGHT + 1) / 2;
  localparam int BD = HW * HH;
  localparam int BA = (BD > 1) ? $clog2(BD) : 1;
  localparam int WT = 2 * F + 1;
  localparam int AW = WT + 10;
  localparam int OW_MAX = 1 << OUT_COORD_BITS;

  logic [8:0]  src_w_q, src_h_q;
  logic [12:0] out_w_q, out_h_q;
  logic        img_valid_q;
  logic [23:0] fill_q;
  logic [2:0]  busy_q;
  logic        cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q     <= RST_SRC_WIDTH;
      src_h_q     <= RST_SRC_HEIGHT;
      out_w_q     <= RST_OUT_WIDTH;
      out_h_q     <= RST_OUT_HEIGHT;
      img_valid_q <= 1'b0;
      fill_q      <= RST_FILL_COLOR;
      busy_q      <= SETTLE_CYCLES;
    end else begin
      if (cfg_wr) begin
        busy_q <= SETTLE_CYCLES;
        case (cfg_index_i)
          CFG_SRC_WIDTH:   src_w_q     <= cfg_data_i[8:0];
          CFG_SRC_HEIGHT:  src_h_q     <= cfg_data_i[8:0];
          CFG_OUT_WIDTH:   out_w_q     <= cfg_data_i[12:0];
          CFG_OUT_HEIGHT:  out_h_q     <= cfg_data_i[12:0];
          CFG_IMAGE_VALID: img_valid_q <= cfg_data_i[0];
          CFG_FILL_COLOR:  fill_q      <= cfg_data_i;
          default: ;
        endcase
      end else if (busy_q != 3'd0) begin
        busy_q <= busy_q - 3'd1;
      end
    end
  end

  // Placement registers, recomputed from the configuration every cycle.
  logic [SB-1:0] w_q, h_q, den_q;
  logic [OB-1:0] ow_q, oh_q, num_q;
  logic [MW-1:0] pa_q, pb_q, owd_q, wn_q, ohd_q, hn_q;
  logic [PW-1:0] xa_q, xc_q, ya_q, yc_q;
  logic [SB:0]   b2_q;
  logic [DW-1:0] d2_q;
  logic [FW-1:0] xlim_q, ylim_q;

  always_ff @(posedge clk_i) begin
    w_q <= (src_w_q == 9'd0) ? SB'(1) :
           ((32'(src_w_q) > 32'(MAX_SRC_WIDTH)) ? SB'(MAX_SRC_WIDTH) : SB'(src_w_q));
    h_q <= (src_h_q == 9'd0) ? SB'(1) :
           ((32'(src_h_q) > 32'(MAX_SRC_HEIGHT)) ? SB'(MAX_SRC_HEIGHT) : SB'(src_h_q));
    ow_q   <= (32'(out_w_q) > 32'(OW_MAX)) ? OB'(OW_MAX) : OB'(out_w_q);
    oh_q   <= (32'(out_h_q) > 32'(OW_MAX)) ? OB'(OW_MAX) : OB'(out_h_q);
    pa_q   <= MW'(oh_q) * MW'(w_q);
    pb_q   <= MW'(ow_q) * MW'(h_q);
    num_q  <= (pa_q >= pb_q) ? ow_q : oh_q;
    den_q  <= (pa_q >= pb_q) ? w_q : h_q;
    owd_q  <= MW'(ow_q) * MW'(den_q);
    wn_q   <= MW'(w_q) * MW'(num_q);
    ohd_q  <= MW'(oh_q) * MW'(den_q);
    hn_q   <= MW'(h_q) * MW'(num_q);
    xa_q   <= PW'(owd_q) - PW'(wn_q);
    xc_q   <= PW'(owd_q) + PW'(wn_q);
    ya_q   <= PW'(ohd_q) - PW'(hn_q);
    yc_q   <= PW'(ohd_q) + PW'(hn_q);
    b2_q   <= {den_q, 1'b0};
    d2_q   <= {num_q, 1'b0};
    xlim_q <= {SB'(w_q - SB'(1)), {F{1'b0}}};
    ylim_q <= {SB'(h_q - SB'(1)), {F{1'b0}}};
  end

  // Pipeline: all stages advance together unless the spare output register is occupied.
  logic  adv, out_valid_q, in_ld, sk_vld_q;
  side_t in_q, s1_q, s3_q, s4_q, s5_q, s6_q;
  side_t sb_q [1:NW];

  assign adv        = !sk_vld_q;
  assign in_stall_o = (busy_q != 3'd0) || (in_q.vld && !adv);
  assign in_ld      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else if (adv || !in_q.vld) begin
      in_q <= '{vld: in_ld, op: operation_i, in_rect: 1'b0, x: coord_x_i, y: coord_y_i,
                pix: pixel_in_i};
    end
  end

  logic [PW-1:0] mx_q, my_q, nx_q, ny_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (adv) begin
      s1_q <= '{vld: in_q.vld, op: in_q.op,
                in_rect: img_valid_q && (32'(in_q.x) < 32'(ow_q)) &&
                         (32'(in_q.y) < 32'(oh_q)),
                x: in_q.x, y: in_q.y, pix: in_q.pix};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mx_q <= PW'({1'b0, in_q.x} + 13'd1) * PW'(b2_q);
      my_q <= PW'({1'b0, in_q.y} + 13'd1) * PW'(b2_q);
      nx_q <= PW'({in_q.x, 1'b0}) * PW'(den_q);
      ny_q <= PW'({in_q.y, 1'b0}) * PW'(den_q);
    end
  end

  logic [NW-1:0] dvx, dvy, qx, qy;
  logic          inside_b;

  assign dvx = (nx_q > xa_q) ? {PW'(nx_q - xa_q), {F{1'b0}}} : '0;
  assign dvy = (ny_q > ya_q) ? {PW'(ny_q - ya_q), {F{1'b0}}} : '0;
  assign inside_b = s1_q.in_rect && (mx_q > xa_q) && (mx_q <= xc_q) &&
                    (my_q > ya_q) && (my_q <= yc_q);

  bcs_div #(.NW(NW), .DW(DW)) u_div_x (
    .clk_i, .en_i(adv), .dividend_i(dvx), .divisor_i(d2_q), .quotient_o(qx)
  );
  bcs_div #(.NW(NW), .DW(DW)) u_div_y (
    .clk_i, .en_i(adv), .dividend_i(dvy), .divisor_i(d2_q), .quotient_o(qy)
  );

  for (genvar k = 1; k <= NW; k++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sb_q[k] <= '0;
      end else if (adv) begin
        if (k == 1) begin
          sb_q[k] <= '{vld: s1_q.vld, op: s1_q.op, in_rect: inside_b, x: s1_q.x, y: s1_q.y,
                       pix: s1_q.pix};
        end else begin
          sb_q[k] <= sb_q[(k > 1) ? k - 1 : 1];
        end
      end
    end
  end

  logic [FW-1:0] fx_q, fy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else if (adv) begin
      s3_q <= sb_q[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fx_q <= (qx > NW'(xlim_q)) ? xlim_q : FW'(qx);
      fy_q <= (qy > NW'(ylim_q)) ? ylim_q : FW'(qy);
    end
  end

  // Neighbor addressing: x0 and x0+1 always fall into banks of opposite column parity.
  logic [SB-1:0] x0, y0, x1, y1;
  logic          xeq, yeq;
  logic [SB:0]   cex, cox, rey, roy;
  logic [BA-1:0] rd_addr [4];
  logic [BA-1:0] wr_addr;
  logic [3:0]    wr_en;
  logic          st_ok;

  always_comb begin
    x0  = fx_q[FW-1:F];
    y0  = fy_q[FW-1:F];
    x1  = (32'(x0) + 32'd1 < 32'(w_q)) ? SB'(x0 + SB'(1)) : x0;
    y1  = (32'(y0) + 32'd1 < 32'(h_q)) ? SB'(y0 + SB'(1)) : y0;
    xeq = (x1 == x0);
    yeq = (y1 == y0);
    cox = (SB+1)'(x0) >> 1;
    cex = ((SB+1)'(x0) + (SB+1)'(1)) >> 1;
    if (32'(cex) > 32'(HW - 1)) begin
      cex = (SB+1)'(HW - 1);
    end
    roy = (SB+1)'(y0) >> 1;
    rey = ((SB+1)'(y0) + (SB+1)'(1)) >> 1;
    if (32'(rey) > 32'(HH - 1)) begin
      rey = (SB+1)'(HH - 1);
    end
    for (int b = 0; b < 4; b++) begin
      rd_addr[b] = BA'(32'((b >= 2) ? roy : rey) * 32'(HW) + 32'(b[0] ? cox : cex));
    end
    st_ok   = s3_q.vld && (s3_q.op == OP_STORE) &&
              (32'(s3_q.x) < 32'(MAX_SRC_WIDTH)) && (32'(s3_q.y) < 32'(MAX_SRC_HEIGHT));
    wr_addr = BA'(32'(s3_q.y >> 1) * 32'(HW) + 32'(s3_q.x >> 1));
    for (int b = 0; b < 4; b++) begin
      wr_en[b] = st_ok && (2'(b) == {s3_q.y[0], s3_q.x[0]});
    end
  end

  logic [23:0] rd_q [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [23:0] mem [BD];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (wr_en[b]) begin
          mem[wr_addr] <= s3_q.pix;
        end
        rd_q[b] <= mem[rd_addr[b]];
      end
    end
  end

  logic [F-1:0] tx_q, ty_q;
  logic         px_q, py_q, xeq_q, yeq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_q <= '0;
    end else if (adv) begin
      s4_q <= s3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tx_q  <= fx_q[F-1:0];
      ty_q  <= fy_q[F-1:0];
      px_q  <= x0[0];
      py_q  <= y0[0];
      xeq_q <= xeq;
      yeq_q <= yeq;
    end
  end

  logic [23:0]   c0, c1, c2, c3;
  logic [F:0]    omtx, omty;
  logic [23:0]   c_q [4];
  logic [WT-1:0] wt_q [4];

  always_comb begin
    c0   = rd_q[{py_q, px_q}];
    c1   = xeq_q ? c0 : rd_q[{py_q, ~px_q}];
    c2   = yeq_q ? c0 : rd_q[{~py_q, px_q}];
    c3   = xeq_q ? c2 : (yeq_q ? c1 : rd_q[{~py_q, ~px_q}]);
    omtx = (F+1)'(1 << F) - (F+1)'(tx_q);
    omty = (F+1)'(1 << F) - (F+1)'(ty_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_q <= '0;
      s6_q <= '0;
    end else if (adv) begin
      s5_q <= s4_q;
      s6_q <= s5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q[0]  <= c0;
      c_q[1]  <= c1;
      c_q[2]  <= c2;
      c_q[3]  <= c3;
      wt_q[0] <= WT'(WT'(omtx) * WT'(omty));
      wt_q[1] <= WT'(WT'(tx_q) * WT'(omty));
      wt_q[2] <= WT'(WT'(omtx) * WT'(ty_q));
      wt_q[3] <= WT'(WT'(tx_q) * WT'(ty_q));
    end
  end

  logic [AW-1:0] prod_q [3][4];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int i = 0; i < 4; i++) begin
          prod_q[ch][i] <= AW'(c_q[i][8*ch +: 8]) * AW'(wt_q[i]);
        end
      end
    end
  end

  logic [AW-1:0] acc [3];
  logic [23:0]   rgb;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch] = prod_q[ch][0] + prod_q[ch][1] + prod_q[ch][2] + prod_q[ch][3] +
                AW'(1 << (2 * F - 1));
      acc[ch] = acc[ch] >> (2 * F);
      rgb[8*ch +: 8] = (acc[ch] > AW'(255)) ? 8'hff : acc[ch][7:0];
    end
  end

  logic [31:0] pix_out_q, sk_pix_q, res_pix;
  logic        inside_q, sk_in_q, res_vld, out_take;

  assign res_vld  = s6_q.vld && (s6_q.op == OP_COMPUTE);
  assign res_pix  = {ALPHA, s6_q.in_rect ? rgb : fill_q};
  assign out_take = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sk_vld_q    <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= sk_vld_q || res_vld;
      sk_vld_q    <= 1'b0;
    end else if (res_vld) begin
      sk_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      pix_out_q <= sk_vld_q ? sk_pix_q : res_pix;
      inside_q  <= sk_vld_q ? sk_in_q : s6_q.in_rect;
    end else if (adv) begin
      sk_pix_q <= res_pix;
      sk_in_q  <= s6_q.in_rect;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_out_o    = pix_out_q;
  assign inside_image_o = inside_q;

`ifndef SYNTHESIS
  a_cfg_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> in_stall_o)
    else $error("input taken while placement registers settle");

  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pixel_out_o[31:24] == ALPHA)
    else $error("alpha channel is not opaque");

  a_no_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !img_valid_q |-> !inside_image_o)
    else $error("pixel marked inside with no image loaded");
`endif

endmodule
`default_nettype wire

### sv/bcs_div.sv
`default_nettype none
module bcs_div #(
  parameter int NW = 32,
  parameter int DW = 14
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic      [NW-1:0] quotient_o
);

  logic [DW-1:0] rem_q [1:NW];
  logic [NW-1:0] dvd_q [1:NW];
  logic [DW-1:0] dsr_q [1:NW];
  logic [NW-1:0] quo_q [1:NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [NW-1:0] dvd_in;
    logic [DW-1:0] dsr_in;
    logic [NW-1:0] quo_in;
    logic [DW:0]   trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign dvd_in = dividend_i;
      assign dsr_in = divisor_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i];
      assign dvd_in = dvd_q[i];
      assign dsr_in = dsr_q[i];
      assign quo_in = quo_q[i];
    end

    assign trial = {rem_in, dvd_in[NW-1-i]};
    assign ge    = trial >= {1'b0, dsr_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1] <= ge ? DW'(trial - {1'b0, dsr_in}) : DW'(trial);
        dvd_q[i+1] <= dvd_in;
        dsr_q[i+1] <= dsr_in;
        quo_q[i+1] <= quo_in | (NW'(ge) << (NW - 1 - i));
      end
    end
  end

  assign quotient_o = quo_q[NW];

endmodule
`default_nettype wire

### sim/bcs_checker.sv
`timescale 1ns / 1ps
module bcs_checker
  import bcs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic        operation_i,
  input  wire logic [11:0] coord_x_i,
  input  wire logic [11:0] coord_y_i,
  input  wire logic [23:0] pixel_in_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [31:0] pixel_out_i,
  input  wire logic        inside_image_i,
  output int               errors_o,
  output int               pending_o
);

  typedef struct {
    logic [31:0] pixel;
    logic        in_rect;
  } argb_t;

  logic [23:0] image_mem [0:65535];
  logic [8:0]  src_w_q, src_h_q;
  logic [12:0] out_w_q, out_h_q;
  logic        valid_q;
  logic [23:0] fill_q;
  argb_t       pixel_q[$];

  assign pending_o = pixel_q.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch in %s: got %h, expected %h at %0t", what, got, want, $realtime);
    errors_o++;
  endtask

  function automatic longint unsigned axis_coord(longint unsigned p, longint unsigned o,
                                                 longint unsigned s, longint unsigned num,
                                                 longint unsigned den);
    longint unsigned pos, neg, v, lim;
    pos = 2 * p * den + s * num;
    neg = o * den;
    if (pos <= neg) return 0;
    v = ((pos - neg) << 8) / (2 * num);
    lim = (s - 1) << 8;
    return (v > lim) ? lim : v;
  endfunction

  function automatic logic [31:0] blend(longint unsigned fx, longint unsigned fy,
                                        longint unsigned w, longint unsigned h);
    longint unsigned x0, x1, y0, y1, tx, ty, acc;
    longint unsigned wt [4];
    logic [23:0] c [4];
    logic [31:0] res;
    x0 = fx >> 8;
    y0 = fy >> 8;
    x1 = (x0 + 1 < w) ? x0 + 1 : x0;
    y1 = (y0 + 1 < h) ? y0 + 1 : y0;
    tx = fx & 255;
    ty = fy & 255;
    c[0] = image_mem[y0 * 256 + x0];
    c[1] = image_mem[y0 * 256 + x1];
    c[2] = image_mem[y1 * 256 + x0];
    c[3] = image_mem[y1 * 256 + x1];
    wt[0] = (256 - tx) * (256 - ty);
    wt[1] = tx * (256 - ty);
    wt[2] = (256 - tx) * ty;
    wt[3] = tx * ty;
    res = {ALPHA, 24'h0};
    for (int ch = 0; ch < 3; ch++) begin
      acc = 1 << 15;
      for (int i = 0; i < 4; i++) acc += longint'(c[i][ch*8 +: 8]) * wt[i];
      acc >>= 16;
      if (acc > 255) acc = 255;
      res[ch*8 +: 8] = acc[7:0];
    end
    return res;
  endfunction

  function automatic argb_t letterbox_pixel(logic [11:0] x, logic [11:0] y);
    longint unsigned w, h, ow, oh, num, den, xlo, xhi, ylo, yhi;
    argb_t r;
    w  = (src_w_q == 0) ? 1 : ((src_w_q > 256) ? 256 : src_w_q);
    h  = (src_h_q == 0) ? 1 : ((src_h_q > 256) ? 256 : src_h_q);
    ow = (out_w_q > 4096) ? 4096 : out_w_q;
    oh = (out_h_q > 4096) ? 4096 : out_h_q;
    r.pixel = {ALPHA, fill_q};
    r.in_rect = 1'b0;
    if (valid_q && x < ow && y < oh) begin
      if (oh * w >= ow * h) begin
        num = ow;
        den = w;
      end else begin
        num = oh;
        den = h;
      end
      xlo = (ow * den - w * num) / (2 * den);
      xhi = (ow * den + w * num) / (2 * den);
      ylo = (oh * den - h * num) / (2 * den);
      yhi = (oh * den + h * num) / (2 * den);
      if (x >= xlo && x < xhi && y >= ylo && y < yhi) begin
        r.in_rect = 1'b1;
        r.pixel = blend(axis_coord(x, ow, w, num, den), axis_coord(y, oh, h, num, den), w, h);
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= RST_SRC_WIDTH;
      src_h_q <= RST_SRC_HEIGHT;
      out_w_q <= RST_OUT_WIDTH;
      out_h_q <= RST_OUT_HEIGHT;
      valid_q <= 1'b0;
      fill_q  <= RST_FILL_COLOR;
      errors_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SRC_WIDTH: begin
            src_w_q <= cfg_data_i[8:0];
          end
          CFG_SRC_HEIGHT: begin
            src_h_q <= cfg_data_i[8:0];
          end
          CFG_OUT_WIDTH: begin
            out_w_q <= cfg_data_i[12:0];
          end
          CFG_OUT_HEIGHT: begin
            out_h_q <= cfg_data_i[12:0];
          end
          CFG_IMAGE_VALID: begin
            valid_q <= cfg_data_i[0];
          end
          CFG_FILL_COLOR: begin
            fill_q <= cfg_data_i;
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (operation_i == OP_STORE) begin
          if (coord_x_i < 256 && coord_y_i < 256)
            image_mem[{coord_y_i[7:0], coord_x_i[7:0]}] = pixel_in_i;
        end else begin
          pixel_q.push_back(letterbox_pixel(coord_x_i, coord_y_i));
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (pixel_q.size() == 0) begin
          report("unexpected word", pixel_out_i, 32'h0);
        end else begin
          argb_t e;
          e = pixel_q.pop_front();
          if (pixel_out_i !== e.pixel) report("pixel_out", pixel_out_i, e.pixel);
          if (inside_image_i !== e.in_rect)
            report("inside_image", 32'(inside_image_i), 32'(e.in_rect));
        end
      end
    end
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import bcs_pkg::*;

  localparam logic [2:0] CFG_SPARE_A = 3'd6;
  localparam logic [2:0] CFG_SPARE_B = 3'd7;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = CFG_SRC_WIDTH;
  logic [23:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        operation_i = OP_STORE;
  logic [11:0] coord_x_i = '0;
  logic [11:0] coord_y_i = '0;
  logic [23:0] pixel_in_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] pixel_out_o;
  logic        inside_image_o;

  int errors, pending, cycles, sent_items;
  bit quiet, hold_pending;

  always #4 clk_i = ~clk_i;

  bilinear_contain_scaler_top dut (.*);

  bcs_checker checker_i (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .operation_i, .coord_x_i, .coord_y_i, .pixel_in_i,
    .out_valid_i(out_valid_o), .out_stall_i, .pixel_out_i(pixel_out_o),
    .inside_image_i(inside_image_o), .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[bilinear_contain_scaler_top] ERROR");
      $finish;
    end
  end

  // The receiver stalls in random bursts, and once for a long stretch on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send(logic op, logic [11:0] x, logic [11:0] y, logic [23:0] pix);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    coord_x_i   <= x;
    coord_y_i   <= y;
    pixel_in_i  <= pix;
    do @(posedge clk_i); while (in_stall_o);
    sent_items++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [8:0] sw, logic [8:0] sh, logic [12:0] ow, logic [12:0] oh,
                           logic valid, logic [23:0] fill, int n);
    int w, h, owe, ohe;
    logic [11:0] x, y;
    w   = (sw == 0) ? 1 : ((sw > 256) ? 256 : sw);
    h   = (sh == 0) ? 1 : ((sh > 256) ? 256 : sh);
    owe = (ow > 4096) ? 4096 : ow;
    ohe = (oh > 4096) ? 4096 : oh;
    wait_idle();
    write_reg(CFG_SRC_WIDTH, 24'(sw));
    write_reg(CFG_SRC_HEIGHT, 24'(sh));
    write_reg(CFG_OUT_WIDTH, 24'(ow));
    write_reg(CFG_OUT_HEIGHT, 24'(oh));
    write_reg(CFG_IMAGE_VALID, 24'(valid));
    write_reg(CFG_FILL_COLOR, fill);
    write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 24'($urandom));
    cfg_valid_i <= 1'b0;
    for (int j = 0; j < h; j++)
      for (int i = 0; i < w; i++) send(OP_STORE, 12'(i), 12'(j), 24'($urandom));
    send(OP_COMPUTE, 12'h0, 12'h0, 24'h0);
    send(OP_COMPUTE, 12'(owe - 1), 12'(ohe - 1), 24'h0);
    send(OP_COMPUTE, 12'hfff, 12'hfff, 24'hffffff);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) != 0) begin
        x = (owe > 0 && $urandom_range(0, 5) != 0) ? 12'($urandom_range(0, owe - 1))
                                                     : 12'($urandom);
        y = (ohe > 0 && $urandom_range(0, 5) != 0) ? 12'($urandom_range(0, ohe - 1))
                                                     : 12'($urandom);
        send(OP_COMPUTE, x, y, 24'($urandom));
      end else if ($urandom_range(0, 1) != 0) begin
        send(OP_STORE, 12'($urandom_range(0, w - 1)), 12'($urandom_range(0, h - 1)),
             24'($urandom));
      end else begin
        send(OP_STORE, 12'($urandom), 12'($urandom), 24'($urandom));
      end
    end
  endtask

  initial begin
    logic [8:0] sw, sh;
    logic [12:0] ow, oh;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    send(OP_COMPUTE, 12'h0, 12'h0, 24'h0);
    send(OP_STORE, 12'hfff, 12'h0, 24'hffffff);
    send(OP_STORE, 12'h0, 12'hfff, 24'hffffff);
    send(OP_COMPUTE, 12'hfff, 12'hfff, 24'hffffff);
    run_phase(9'd1, 9'd1, 13'd4096, 13'd1, 1'b1, 24'h000000, 3);
    run_phase(9'h1ff, 9'd1, 13'h1fff, 13'h1fff, 1'b1, 24'hffffff, 3);
    run_phase(9'd0, 9'd300, 13'd0, 13'd0, 1'b1, 24'h123456, 2);
    run_phase(9'd4, 9'd3, 13'd5, 13'd300, 1'b0, 24'h00ff00, 3);

    hold_pending = 1'b1;
    run_phase(9'd3, 9'd2, 13'd16, 13'd16, 1'b1, 24'h0d1117, 40);
    while (sent_items < 700) begin
      if (sent_items > 600) quiet = 1'b1;
      sw = ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(1, 8));
      sh = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 4)) : 9'($urandom_range(1, 8));
      if (sw > 8) sh = 9'($urandom_range(0, 2));
      ow = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'($urandom_range(1, 64));
      oh = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'($urandom_range(1, 64));
      run_phase(sw, sh, ow, oh, $urandom_range(0, 9) != 0, 24'($urandom), 50);
    end

    wait_idle();
    if (errors == 0) begin
      $display("[bilinear_contain_scaler_top] OK");
    end else begin
      $display("[bilinear_contain_scaler_top] ERROR");
    end
    $finish;
  end

endmodule
